FILE: rtl/cgs_pkg.sv
// cgs_pkg: shared constants, codes and types of the cave grid smoother
// depends on nothing; used by every module of the block
package cgs_pkg;

	// fixed field widths of the item and result ports and the pass count
	localparam int ACTION_W = 2;
	localparam int CX_W     = 6;
	localparam int CY_W     = 6;
	localparam int NB_W     = 4;
	localparam int PASS_W   = 4;

	// default grid size
	localparam int DEF_GRID_W = 64;
	localparam int DEF_GRID_H = 64;

	// neighbour count at which a cell keeps its old value
	localparam logic [NB_W-1:0] KEEP_COUNT = 4'd4;

	// reset value of the pass count register
	localparam logic [PASS_W-1:0] SMOOTH_PASSES_RST = 4'd5;

	// configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [0:0] REG_SMOOTH_PASSES = 1'b0;

	// item action codes
	localparam logic [ACTION_W-1:0] ACT_WRITE  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_SMOOTH = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_LOAD,
		ST_SWEEP,
		ST_WRITE,
		ST_RESPOND
	} state_t;

endpackage

FILE: rtl/cgs_row_mem.sv
// cgs_row_mem: grid store, one row of cells per word, bit-enabled write
// one write and one registered read per cycle; uses cgs_pkg for defaults
module cgs_row_mem
	import cgs_pkg::*;
#(
	parameter int GRID_W = DEF_GRID_W,
	parameter int GRID_H = DEF_GRID_H,
	localparam int RA_W  = $clog2(GRID_H)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [RA_W-1:0]   wr_row,
	input  logic [GRID_W-1:0] wr_mask,
	input  logic [GRID_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [RA_W-1:0]   rd_row,
	output logic [GRID_W-1:0] rd_data
);

	logic [GRID_W-1:0] mem [GRID_H];

	// masked row write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int i = 0; i < GRID_W; i++) begin
				if (wr_mask[i]) begin
					mem[wr_row][i] <= wr_data[i];
				end
			end
		end
	end

	// registered row read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_row];
		end
	end

endmodule

FILE: rtl/cgs_nbr_unit.sv
// cgs_nbr_unit: shared neighbour unit, one cell of a three-row window per cycle
// counts walls around the selected column and applies the 4-5 rule; uses cgs_pkg
module cgs_nbr_unit
	import cgs_pkg::*;
#(
	parameter int GRID_W = DEF_GRID_W,
	parameter int FC_W   = CX_W + 1,
	localparam int CA_W  = $clog2(GRID_W)
) (
	input  logic [GRID_W-1:0] above,
	input  logic [GRID_W-1:0] centre,
	input  logic [GRID_W-1:0] below,
	input  logic [FC_W-1:0]   col,
	output logic [NB_W-1:0]   wall_count,
	output logic              centre_bit,
	output logic              next_bit
);

	logic [FC_W-1:0] col_l;
	logic [FC_W-1:0] col_r;
	logic [7:0]      nbr;

	// cell of a row at a column counted from one; off-grid columns are walls
	function automatic logic pick(input logic [GRID_W-1:0] row, input logic [FC_W-1:0] p);
		logic [FC_W-1:0] q;
		q = p - FC_W'(1);
		if (p == '0 || 32'(p) > GRID_W) begin
			return 1'b1;
		end
		return row[q[CA_W-1:0]];
	endfunction

	// the eight neighbours
	always_comb begin
		col_l = col - FC_W'(1);
		col_r = col + FC_W'(1);
		nbr[0] = pick(above, col_l);
		nbr[1] = pick(above, col);
		nbr[2] = pick(above, col_r);
		nbr[3] = pick(centre, col_l);
		nbr[4] = pick(centre, col_r);
		nbr[5] = pick(below, col_l);
		nbr[6] = pick(below, col);
		nbr[7] = pick(below, col_r);
		centre_bit = pick(centre, col);
	end

	// wall count
	always_comb begin
		wall_count = '0;
		for (int i = 0; i < 8; i++) begin
			wall_count = wall_count + NB_W'(nbr[i]);
		end
	end

	// 4-5 rule
	always_comb begin
		priority if (wall_count > KEEP_COUNT) begin
			next_bit = 1'b1;
		end else if (wall_count < KEEP_COUNT) begin
			next_bit = 1'b0;
		end else begin
			next_bit = centre_bit;
		end
	end

endmodule

FILE: rtl/cave_grid_smoother.sv
// cave_grid_smoother: top level with sequencer, pass register and result register
// uses cgs_pkg, cgs_row_mem and cgs_nbr_unit
//
// Holds a GRID_W x GRID_H wall/floor grid in a row-wide memory. After reset the
// block clears every row of the grid to floor and takes no item until done. For
// a cell write, and an unused action code, the result is registered at the edge
// that accepts the item. A read fetches three rows through the single read port
// into the row window before its result. A smooth item runs smooth_passes
// passes; each pass fetches rows one at a time into a three-row window and the
// shared neighbour unit works out one cell per cycle, writing each new row back
// to the grid. The block takes one item at a time.
module cave_grid_smoother
	import cgs_pkg::*;
#(
	parameter int GRID_W = DEF_GRID_W,
	parameter int GRID_H = DEF_GRID_H
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// item channel
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [ACTION_W-1:0]   action,
	input  logic [CX_W-1:0]       cell_x,
	input  logic [CY_W-1:0]       cell_y,
	input  logic                  cell_value,
	// result channel
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic                  read_value,
	output logic [NB_W-1:0]       wall_neighbours,
	output logic                  acknowledge,
	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int RA_W    = $clog2(GRID_H);
	localparam int CA_W    = $clog2(GRID_W);
	localparam int FR_BASE = $clog2(GRID_H + 3);
	localparam int FR_W    = (FR_BASE > CY_W + 1) ? FR_BASE : CY_W + 1;
	localparam int FC_BASE = $clog2(GRID_W + 2);
	localparam int FC_W    = (FC_BASE > CX_W + 1) ? FC_BASE : CX_W + 1;

	state_t              state_q;
	state_t              state_d;
	logic [PASS_W-1:0]   smooth_passes_q;
	logic [FR_W-1:0]     fetch_q;
	logic [1:0]          load_q;
	logic [FC_W-1:0]     col_q;
	logic [PASS_W-1:0]   pass_q;
	logic                op_smooth_q;
	logic [GRID_W-1:0]   above_q;
	logic [GRID_W-1:0]   centre_q;
	logic [GRID_W-1:0]   below_q;
	logic [GRID_W-1:0]   newrow_q;
	logic                result_valid_q;
	logic                read_value_q;
	logic [NB_W-1:0]     wall_neighbours_q;
	logic                acknowledge_q;

	logic                accept;
	logic                out_free;
	logic                cfg_write;
	logic                row_on_grid;
	logic                row_last;
	logic                pass_last;
	logic                cell_on_grid;
	logic                mem_we;
	logic [RA_W-1:0]     mem_wr_row;
	logic [GRID_W-1:0]   mem_wr_mask;
	logic [GRID_W-1:0]   mem_wr_data;
	logic                mem_re;
	logic [RA_W-1:0]     mem_rd_row;
	logic [GRID_W-1:0]   mem_rd_data;
	logic [GRID_W-1:0]   load_row;
	logic [NB_W-1:0]     unit_count;
	logic                unit_centre;
	logic                unit_next;

	// configuration register
	assign cfg_write = psel && penable && pwrite && pready;
	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == REG_SMOOTH_PASSES) ? APB_DATA_W'(smooth_passes_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_passes_q <= SMOOTH_PASSES_RST;
		end else if (cfg_write && paddr[2] == REG_SMOOTH_PASSES) begin
			smooth_passes_q <= pwdata[PASS_W-1:0];
		end
	end

	// handshake
	assign out_free   = !result_valid_q || !result_stall;
	assign item_stall = (state_q != ST_IDLE) || !out_free;
	assign accept     = item_valid && !item_stall;

	// status decodes
	assign row_on_grid  = (fetch_q != '0) && (32'(fetch_q) <= GRID_H);
	assign row_last     = (32'(fetch_q) == GRID_H + 2);
	assign pass_last    = ((pass_q + PASS_W'(1)) == smooth_passes_q);
	assign cell_on_grid = (32'(cell_x) < GRID_W) && (32'(cell_y) < GRID_H);
	assign load_row     = row_on_grid ? mem_rd_data : '1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (32'(fetch_q) == GRID_H - 1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (action == ACT_READ) begin
						state_d = ST_FETCH;
					end else if (action == ACT_SMOOTH) begin
						state_d = (smooth_passes_q == '0) ? ST_RESPOND : ST_FETCH;
					end
				end
			end
			ST_FETCH: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (load_q == 2'd1) begin
					state_d = op_smooth_q ? ST_SWEEP : ST_RESPOND;
				end else begin
					state_d = ST_FETCH;
				end
			end
			ST_SWEEP: begin
				if (32'(col_q) == GRID_W) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				state_d = (row_last && pass_last) ? ST_RESPOND : ST_FETCH;
			end
			ST_RESPOND: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// memory controls
	always_comb begin
		mem_we      = 1'b0;
		mem_wr_row  = RA_W'(fetch_q);
		mem_wr_mask = '1;
		mem_wr_data = '0;
		mem_re      = 1'b0;
		mem_rd_row  = RA_W'(fetch_q - FR_W'(1));
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				mem_we      = accept && (action == ACT_WRITE) && cell_on_grid;
				mem_wr_row  = RA_W'(cell_y);
				mem_wr_mask = GRID_W'(1) << CA_W'(cell_x);
				mem_wr_data = {GRID_W{cell_value}};
			end
			ST_FETCH: begin
				mem_re = 1'b1;
			end
			ST_WRITE: begin
				mem_we      = 1'b1;
				mem_wr_row  = RA_W'(fetch_q - FR_W'(3));
				mem_wr_data = newrow_q;
			end
			ST_LOAD, ST_SWEEP, ST_RESPOND: begin
				mem_we = 1'b0;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			fetch_q     <= '0;
			load_q      <= '0;
			col_q       <= '0;
			pass_q      <= '0;
			op_smooth_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_CLEAR: begin
					fetch_q <= fetch_q + FR_W'(1);
				end
				ST_IDLE: begin
					if (accept) begin
						op_smooth_q <= (action == ACT_SMOOTH);
						load_q      <= 2'd3;
						pass_q      <= '0;
						if (action == ACT_SMOOTH) begin
							fetch_q <= '0;
							col_q   <= FC_W'(1);
						end else begin
							fetch_q <= FR_W'(cell_y);
							col_q   <= FC_W'(cell_x) + FC_W'(1);
						end
					end
				end
				ST_LOAD: begin
					fetch_q <= fetch_q + FR_W'(1);
					load_q  <= load_q - 2'd1;
				end
				ST_SWEEP: begin
					col_q <= col_q + FC_W'(1);
				end
				ST_WRITE: begin
					col_q <= FC_W'(1);
					if (row_last) begin
						pass_q  <= pass_q + PASS_W'(1);
						fetch_q <= '0;
						load_q  <= 2'd3;
					end else begin
						load_q <= 2'd1;
					end
				end
				ST_FETCH, ST_RESPOND: begin
					load_q <= load_q;
				end
				default: begin
					load_q <= load_q;
				end
			endcase
		end
	end

	// row window and new row
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			above_q  <= centre_q;
			centre_q <= below_q;
			below_q  <= load_row;
		end
		if (state_q == ST_SWEEP) begin
			newrow_q[CA_W'(col_q - FC_W'(1))] <= unit_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == ST_RESPOND && out_free) begin
			result_valid_q <= 1'b1;
		end else if (accept && action != ACT_READ && action != ACT_SMOOTH) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESPOND && out_free) begin
			read_value_q      <= op_smooth_q ? 1'b0 : unit_centre;
			wall_neighbours_q <= op_smooth_q ? '0 : unit_count;
			acknowledge_q     <= 1'b1;
		end else if (accept && action != ACT_READ && action != ACT_SMOOTH) begin
			read_value_q      <= 1'b0;
			wall_neighbours_q <= '0;
			acknowledge_q     <= (action == ACT_WRITE);
		end
	end

	assign result_valid    = result_valid_q;
	assign read_value      = read_value_q;
	assign wall_neighbours = wall_neighbours_q;
	assign acknowledge     = acknowledge_q;

	// grid store
	cgs_row_mem #(
		.GRID_W (GRID_W),
		.GRID_H (GRID_H)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_row  (mem_wr_row),
		.wr_mask (mem_wr_mask),
		.wr_data (mem_wr_data),
		.rd_en   (mem_re),
		.rd_row  (mem_rd_row),
		.rd_data (mem_rd_data)
	);

	// shared neighbour unit
	cgs_nbr_unit #(
		.GRID_W (GRID_W),
		.FC_W   (FC_W)
	) u_unit (
		.above      (above_q),
		.centre     (centre_q),
		.below      (below_q),
		.col        (col_q),
		.wall_count (unit_count),
		.centre_bit (unit_centre),
		.next_bit   (unit_next)
	);

	// checks
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("grid store written and read in one cycle");

	a_sweep_col: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> (col_q != '0 && 32'(col_q) <= GRID_W))
		else $error("sweep column off the grid");

	a_pass_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> (pass_q < smooth_passes_q))
		else $error("pass count ran past the configured passes");

	a_write_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && action == ACT_WRITE) |=> (result_valid && acknowledge))
		else $error("cell write item gave no acknowledged result");

	a_respond_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESPOND && out_free) |=> (result_valid && state_q == ST_IDLE))
		else $error("finished item not delivered");

endmodule
